[rtl/core/kfs_pkg.sv]
// Shared types, operation codes, operand codes and the step program of the Kalman step block.
package kfs_pkg;

    localparam int Q_W = 32;
    localparam int KFS_FRAC_BITS = 16;
    localparam logic signed [Q_W-1:0] KFS_NOISE_B_ONE = 32'sd0;
    localparam logic signed [Q_W-1:0] KFS_NOISE_B_TWO = 32'sd0;
    localparam logic signed [Q_W-1:0] KFS_CTRL_B_ONE = 32'sd0;
    localparam logic signed [Q_W-1:0] KFS_CTRL_B_TWO = 32'sd0;

    localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

    // Configuration register indexes.
    localparam logic [2:0] CFG_A11 = 3'd0;
    localparam logic [2:0] CFG_A12 = 3'd1;
    localparam logic [2:0] CFG_A21 = 3'd2;
    localparam logic [2:0] CFG_A22 = 3'd3;
    localparam logic [2:0] CFG_C1 = 3'd4;
    localparam logic [2:0] CFG_C2 = 3'd5;
    localparam logic [2:0] CFG_PV = 3'd6;
    localparam logic [2:0] CFG_MV = 3'd7;

    // Operations of the shared units.
    localparam logic [2:0] OP_MUL = 3'd0;
    localparam logic [2:0] OP_ADD = 3'd1;
    localparam logic [2:0] OP_SUB = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_END = 3'd4;

    // Operand codes. Codes with the top bit set live in the scratch memory.
    localparam logic [5:0] R_A11 = 6'd0;
    localparam logic [5:0] R_A12 = 6'd1;
    localparam logic [5:0] R_A21 = 6'd2;
    localparam logic [5:0] R_A22 = 6'd3;
    localparam logic [5:0] R_C1 = 6'd4;
    localparam logic [5:0] R_C2 = 6'd5;
    localparam logic [5:0] R_PV = 6'd6;
    localparam logic [5:0] R_MV = 6'd7;
    localparam logic [5:0] R_E1 = 6'd8;
    localparam logic [5:0] R_E2 = 6'd9;
    localparam logic [5:0] R_P11 = 6'd10;
    localparam logic [5:0] R_P12 = 6'd11;
    localparam logic [5:0] R_P21 = 6'd12;
    localparam logic [5:0] R_P22 = 6'd13;
    localparam logic [5:0] R_Y = 6'd14;
    localparam logic [5:0] R_U = 6'd15;
    localparam logic [5:0] R_BN1 = 6'd16;
    localparam logic [5:0] R_BN2 = 6'd17;
    localparam logic [5:0] R_BU1 = 6'd18;
    localparam logic [5:0] R_BU2 = 6'd19;
    localparam logic [5:0] R_G1 = 6'd20;
    localparam logic [5:0] R_G2 = 6'd21;
    localparam logic [5:0] T_A = 6'd32;
    localparam logic [5:0] T_B = 6'd33;
    localparam logic [5:0] T_XM1 = 6'd34;
    localparam logic [5:0] T_XM2 = 6'd35;
    localparam logic [5:0] T_T11 = 6'd36;
    localparam logic [5:0] T_T12 = 6'd37;
    localparam logic [5:0] T_T21 = 6'd38;
    localparam logic [5:0] T_T22 = 6'd39;
    localparam logic [5:0] T_M11 = 6'd40;
    localparam logic [5:0] T_M12 = 6'd41;
    localparam logic [5:0] T_M21 = 6'd42;
    localparam logic [5:0] T_M22 = 6'd43;
    localparam logic [5:0] T_V1 = 6'd44;
    localparam logic [5:0] T_V2 = 6'd45;
    localparam logic [5:0] T_DEN = 6'd46;
    localparam logic [5:0] T_INN = 6'd47;
    localparam logic [5:0] T_K11 = 6'd48;
    localparam logic [5:0] T_K12 = 6'd49;
    localparam logic [5:0] T_K21 = 6'd50;
    localparam logic [5:0] T_K22 = 6'd51;

    localparam int PC_W = 7;
    localparam logic [PC_W-1:0] PROG_LEN = 7'd86;

    typedef struct packed {
        logic [2:0] op;
        logic [5:0] dst;
        logic [5:0] a;
        logic [5:0] b;
    } uop_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
        logic clip;
    } div_ctl_t;

    function automatic uop_t mk(input logic [2:0] op, input logic [5:0] dst,
                                input logic [5:0] a, input logic [5:0] b);
        uop_t u;
        u.op = op;
        u.dst = dst;
        u.a = a;
        u.b = b;
        return u;
    endfunction

    // One Kalman step as a sequence of two-operand operations.
    function automatic uop_t prog_rom(input logic [PC_W-1:0] pc);
        uop_t u;
        unique case (pc)
            7'd0: u = mk(OP_MUL, T_A, R_A11, R_E1);
            7'd1: u = mk(OP_MUL, T_B, R_A12, R_E2);
            7'd2: u = mk(OP_ADD, T_A, T_A, T_B);
            7'd3: u = mk(OP_MUL, T_B, R_BU1, R_U);
            7'd4: u = mk(OP_ADD, T_XM1, T_A, T_B);
            7'd5: u = mk(OP_MUL, T_A, R_A21, R_E1);
            7'd6: u = mk(OP_MUL, T_B, R_A22, R_E2);
            7'd7: u = mk(OP_ADD, T_A, T_A, T_B);
            7'd8: u = mk(OP_MUL, T_B, R_BU2, R_U);
            7'd9: u = mk(OP_ADD, T_XM2, T_A, T_B);
            7'd10: u = mk(OP_MUL, T_A, R_A11, R_P11);
            7'd11: u = mk(OP_MUL, T_B, R_A12, R_P21);
            7'd12: u = mk(OP_ADD, T_T11, T_A, T_B);
            7'd13: u = mk(OP_MUL, T_A, R_A11, R_P12);
            7'd14: u = mk(OP_MUL, T_B, R_A12, R_P22);
            7'd15: u = mk(OP_ADD, T_T12, T_A, T_B);
            7'd16: u = mk(OP_MUL, T_A, R_A21, R_P11);
            7'd17: u = mk(OP_MUL, T_B, R_A22, R_P21);
            7'd18: u = mk(OP_ADD, T_T21, T_A, T_B);
            7'd19: u = mk(OP_MUL, T_A, R_A21, R_P12);
            7'd20: u = mk(OP_MUL, T_B, R_A22, R_P22);
            7'd21: u = mk(OP_ADD, T_T22, T_A, T_B);
            7'd22: u = mk(OP_MUL, T_A, T_T11, R_A11);
            7'd23: u = mk(OP_MUL, T_B, T_T12, R_A12);
            7'd24: u = mk(OP_ADD, T_A, T_A, T_B);
            7'd25: u = mk(OP_MUL, T_B, R_BN1, R_BN1);
            7'd26: u = mk(OP_MUL, T_B, R_PV, T_B);
            7'd27: u = mk(OP_ADD, T_M11, T_A, T_B);
            7'd28: u = mk(OP_MUL, T_A, T_T11, R_A21);
            7'd29: u = mk(OP_MUL, T_B, T_T12, R_A22);
            7'd30: u = mk(OP_ADD, T_A, T_A, T_B);
            7'd31: u = mk(OP_MUL, T_B, R_BN1, R_BN2);
            7'd32: u = mk(OP_MUL, T_B, R_PV, T_B);
            7'd33: u = mk(OP_ADD, T_M12, T_A, T_B);
            7'd34: u = mk(OP_MUL, T_A, T_T21, R_A11);
            7'd35: u = mk(OP_MUL, T_B, T_T22, R_A12);
            7'd36: u = mk(OP_ADD, T_A, T_A, T_B);
            7'd37: u = mk(OP_MUL, T_B, R_BN2, R_BN1);
            7'd38: u = mk(OP_MUL, T_B, R_PV, T_B);
            7'd39: u = mk(OP_ADD, T_M21, T_A, T_B);
            7'd40: u = mk(OP_MUL, T_A, T_T21, R_A21);
            7'd41: u = mk(OP_MUL, T_B, T_T22, R_A22);
            7'd42: u = mk(OP_ADD, T_A, T_A, T_B);
            7'd43: u = mk(OP_MUL, T_B, R_BN2, R_BN2);
            7'd44: u = mk(OP_MUL, T_B, R_PV, T_B);
            7'd45: u = mk(OP_ADD, T_M22, T_A, T_B);
            7'd46: u = mk(OP_MUL, T_A, T_M11, R_C1);
            7'd47: u = mk(OP_MUL, T_B, T_M12, R_C2);
            7'd48: u = mk(OP_ADD, T_V1, T_A, T_B);
            7'd49: u = mk(OP_MUL, T_A, T_M21, R_C1);
            7'd50: u = mk(OP_MUL, T_B, T_M22, R_C2);
            7'd51: u = mk(OP_ADD, T_V2, T_A, T_B);
            7'd52: u = mk(OP_MUL, T_A, R_C1, T_V1);
            7'd53: u = mk(OP_MUL, T_B, R_C2, T_V2);
            7'd54: u = mk(OP_ADD, T_A, T_A, T_B);
            7'd55: u = mk(OP_ADD, T_DEN, T_A, R_MV);
            7'd56: u = mk(OP_DIV, R_G1, T_V1, T_DEN);
            7'd57: u = mk(OP_DIV, R_G2, T_V2, T_DEN);
            7'd58: u = mk(OP_MUL, T_A, R_C1, T_XM1);
            7'd59: u = mk(OP_MUL, T_B, R_C2, T_XM2);
            7'd60: u = mk(OP_ADD, T_A, T_A, T_B);
            7'd61: u = mk(OP_SUB, T_INN, R_Y, T_A);
            7'd62: u = mk(OP_MUL, T_A, R_G1, T_INN);
            7'd63: u = mk(OP_ADD, R_E1, T_XM1, T_A);
            7'd64: u = mk(OP_MUL, T_A, R_G2, T_INN);
            7'd65: u = mk(OP_ADD, R_E2, T_XM2, T_A);
            7'd66: u = mk(OP_MUL, T_K11, R_G1, R_C1);
            7'd67: u = mk(OP_MUL, T_K12, R_G1, R_C2);
            7'd68: u = mk(OP_MUL, T_K21, R_G2, R_C1);
            7'd69: u = mk(OP_MUL, T_K22, R_G2, R_C2);
            7'd70: u = mk(OP_MUL, T_A, T_K11, T_M11);
            7'd71: u = mk(OP_MUL, T_B, T_K12, T_M21);
            7'd72: u = mk(OP_ADD, T_A, T_A, T_B);
            7'd73: u = mk(OP_SUB, R_P11, T_M11, T_A);
            7'd74: u = mk(OP_MUL, T_A, T_K11, T_M12);
            7'd75: u = mk(OP_MUL, T_B, T_K12, T_M22);
            7'd76: u = mk(OP_ADD, T_A, T_A, T_B);
            7'd77: u = mk(OP_SUB, R_P12, T_M12, T_A);
            7'd78: u = mk(OP_MUL, T_A, T_K21, T_M11);
            7'd79: u = mk(OP_MUL, T_B, T_K22, T_M21);
            7'd80: u = mk(OP_ADD, T_A, T_A, T_B);
            7'd81: u = mk(OP_SUB, R_P21, T_M21, T_A);
            7'd82: u = mk(OP_MUL, T_A, T_K21, T_M12);
            7'd83: u = mk(OP_MUL, T_B, T_K22, T_M22);
            7'd84: u = mk(OP_ADD, T_A, T_A, T_B);
            7'd85: u = mk(OP_SUB, R_P22, T_M22, T_A);
            default: u = mk(OP_END, T_A, T_A, T_A);
        endcase
        return u;
    endfunction

endpackage

[rtl/core/kalman_filter_2state_step_top.sv]
// Top level of the two-state Kalman step: sequencer, operand store and shared units.
//
//  Channel  Direction  Handshake                 Payload
//  input    in         in_valid / in_stall       measurement, control
//  output   out        out_valid / out_stall     est_first, est_second, gain_first,
//                                                gain_second, saturated
//  config   in         cfg_we (no wait)          cfg_index, cfg_data
//
// For each word, 86 program steps run one after another on a shared multiplier,
// a saturating adder and a radix-2 divider, which forms the two gain quotients.
// After reset the estimate is zero and the covariance is identity; no clearing pass.
// The result waits in output registers, so a new word may start while it is stalled;
// the next result is held back until the previous one has been taken.
module kalman_filter_2state_step_top
    import kfs_pkg::*;
#(
    parameter int FRAC_BITS = KFS_FRAC_BITS,
    parameter logic signed [Q_W-1:0] NOISE_B_ONE = KFS_NOISE_B_ONE,
    parameter logic signed [Q_W-1:0] NOISE_B_TWO = KFS_NOISE_B_TWO,
    parameter logic signed [Q_W-1:0] CTRL_B_ONE = KFS_CTRL_B_ONE,
    parameter logic signed [Q_W-1:0] CTRL_B_TWO = KFS_CTRL_B_TWO
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic signed [Q_W-1:0] measurement,
    input  logic signed [Q_W-1:0] control,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [Q_W-1:0] est_first,
    output logic signed [Q_W-1:0] est_second,
    output logic signed [Q_W-1:0] gain_first,
    output logic signed [Q_W-1:0] gain_second,
    output logic                  saturated,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [Q_W-1:0]        cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD = 3'd1;
    localparam logic [2:0] S_EX = 3'd2;
    localparam logic [2:0] S_WB = 3'd3;
    localparam logic [2:0] S_DIVW = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    localparam logic signed [Q_W-1:0] Q_ONE = Q_W'(1) <<< FRAC_BITS;

    logic [2:0]            state_reg;
    logic [PC_W-1:0]       pc_reg;
    logic                  sat_reg;
    logic                  out_valid_reg;
    logic signed [Q_W-1:0] out_e1_reg, out_e2_reg, out_g1_reg, out_g2_reg;
    logic                  out_sat_reg;

    // Configuration registers; the two variances are unsigned 31-bit.
    logic signed [Q_W-1:0] a11_reg, a12_reg, a21_reg, a22_reg, c1_reg, c2_reg;
    logic [Q_W-2:0]        pv_reg, mv_reg;

    // Filter state and per-word values.
    logic signed [Q_W-1:0] e1_reg, e2_reg, p11_reg, p12_reg, p21_reg, p22_reg;
    logic signed [Q_W-1:0] g1_reg, g2_reg, y_reg, u_reg;

    // Scratch store for intermediate products and sums.
    logic signed [Q_W-1:0] mem [32];
    logic signed [Q_W-1:0] mem_a_reg, mem_b_reg;
    logic signed [Q_W-1:0] opa_reg, opb_reg;

    uop_t                  uop;
    logic signed [Q_W-1:0] a_val, b_val;
    logic signed [Q_W:0]   sum;
    logic signed [Q_W-1:0] add_res;
    logic                  add_clip;
    logic signed [Q_W-1:0] mul_res;
    logic                  mul_clip;
    logic                  div_start;
    logic                  div_busy;
    logic                  div_done;
    logic                  div_clip;
    logic signed [Q_W-1:0] div_q;
    logic                  wb_en;
    logic signed [Q_W-1:0] wb_val;
    logic                  wb_clip;
    logic                  in_acc;

    function automatic logic signed [Q_W-1:0] src_val(input logic [5:0] code);
        logic signed [Q_W-1:0] v;
        unique case (code)
            R_A11: v = a11_reg;
            R_A12: v = a12_reg;
            R_A21: v = a21_reg;
            R_A22: v = a22_reg;
            R_C1: v = c1_reg;
            R_C2: v = c2_reg;
            R_PV: v = {1'b0, pv_reg};
            R_MV: v = {1'b0, mv_reg};
            R_E1: v = e1_reg;
            R_E2: v = e2_reg;
            R_P11: v = p11_reg;
            R_P12: v = p12_reg;
            R_P21: v = p21_reg;
            R_P22: v = p22_reg;
            R_Y: v = y_reg;
            R_U: v = u_reg;
            R_BN1: v = NOISE_B_ONE;
            R_BN2: v = NOISE_B_TWO;
            R_BU1: v = CTRL_B_ONE;
            R_BU2: v = CTRL_B_TWO;
            R_G1: v = g1_reg;
            R_G2: v = g2_reg;
            default: v = '0;
        endcase
        return v;
    endfunction

    assign uop = prog_rom(pc_reg);
    assign in_stall = (state_reg != S_IDLE);
    assign in_acc = in_valid && !in_stall;

    // Operands come from the scratch store or from the latched register value.
    assign a_val = uop.a[5] ? mem_a_reg : opa_reg;
    assign b_val = uop.b[5] ? mem_b_reg : opb_reg;

    always_comb
    begin
        if (uop.op == OP_SUB)
        begin
            sum = {a_val[Q_W-1], a_val} - {b_val[Q_W-1], b_val};
        end
        else
        begin
            sum = {a_val[Q_W-1], a_val} + {b_val[Q_W-1], b_val};
        end
        add_clip = sum[Q_W] != sum[Q_W-1];
        add_res = add_clip ? (sum[Q_W] ? Q_MIN : Q_MAX) : sum[Q_W-1:0];
    end

    kfs_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk  (clk),
        .en   (state_reg == S_EX),
        .a    (a_val),
        .b    (b_val),
        .res  (mul_res),
        .clip (mul_clip)
    );

    assign div_start = (state_reg == S_EX) && (uop.op == OP_DIV);

    kfs_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (a_val),
        .den   (b_val),
        .busy  (div_busy),
        .done  (div_done),
        .q     (div_q),
        .clip  (div_clip)
    );

    // Write-back selection: adds retire in the execute cycle, products in the
    // cycle after it, quotients when the divider reports done.
    always_comb
    begin
        wb_en = 1'b0;
        wb_val = add_res;
        wb_clip = add_clip;
        if (state_reg == S_EX && (uop.op == OP_ADD || uop.op == OP_SUB))
        begin
            wb_en = 1'b1;
        end
        else if (state_reg == S_WB)
        begin
            wb_en = 1'b1;
            wb_val = mul_res;
            wb_clip = mul_clip;
        end
        else if (state_reg == S_DIVW && div_done)
        begin
            wb_en = 1'b1;
            wb_val = div_q;
            wb_clip = div_clip;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wb_en && uop.dst[5])
        begin
            mem[uop.dst[4:0]] <= wb_val;
        end
        mem_a_reg <= mem[uop.a[4:0]];
        mem_b_reg <= mem[uop.b[4:0]];
        if (state_reg == S_RD)
        begin
            opa_reg <= src_val(uop.a);
            opb_reg <= src_val(uop.b);
        end
        if (in_acc)
        begin
            y_reg <= measurement;
            u_reg <= control;
        end
        if (wb_en && uop.dst == R_G1)
        begin
            g1_reg <= wb_val;
        end
        if (wb_en && uop.dst == R_G2)
        begin
            g2_reg <= wb_val;
        end
    end

    // Configuration and filter state, both with reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a11_reg <= Q_ONE;
            a12_reg <= '0;
            a21_reg <= '0;
            a22_reg <= Q_ONE;
            c1_reg <= Q_ONE;
            c2_reg <= '0;
            pv_reg <= '0;
            mv_reg <= Q_ONE[Q_W-2:0];
            e1_reg <= '0;
            e2_reg <= '0;
            p11_reg <= Q_ONE;
            p12_reg <= '0;
            p21_reg <= '0;
            p22_reg <= Q_ONE;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_A11: a11_reg <= cfg_data;
                    CFG_A12: a12_reg <= cfg_data;
                    CFG_A21: a21_reg <= cfg_data;
                    CFG_A22: a22_reg <= cfg_data;
                    CFG_C1: c1_reg <= cfg_data;
                    CFG_C2: c2_reg <= cfg_data;
                    CFG_PV: pv_reg <= cfg_data[Q_W-2:0];
                    CFG_MV: mv_reg <= cfg_data[Q_W-2:0];
                    default: ;
                endcase
            end
            if (wb_en)
            begin
                unique case (uop.dst)
                    R_E1: e1_reg <= wb_val;
                    R_E2: e2_reg <= wb_val;
                    R_P11: p11_reg <= wb_val;
                    R_P12: p12_reg <= wb_val;
                    R_P21: p21_reg <= wb_val;
                    R_P22: p22_reg <= wb_val;
                    default: ;
                endcase
            end
        end
    end

    // Step sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg <= '0;
            sat_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            if (wb_en)
            begin
                sat_reg <= sat_reg | wb_clip;
                pc_reg <= pc_reg + 1'b1;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        state_reg <= S_RD;
                        pc_reg <= '0;
                        sat_reg <= 1'b0;
                    end
                end
                S_RD:
                begin
                    state_reg <= (uop.op == OP_END) ? S_DONE : S_EX;
                end
                S_EX:
                begin
                    unique case (uop.op)
                        OP_MUL: state_reg <= S_WB;
                        OP_DIV: state_reg <= S_DIVW;
                        default: state_reg <= S_RD;
                    endcase
                end
                S_WB:
                begin
                    state_reg <= S_RD;
                end
                S_DIVW:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_RD;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && (!out_valid_reg || !out_stall))
        begin
            out_e1_reg <= e1_reg;
            out_e2_reg <= e2_reg;
            out_g1_reg <= g1_reg;
            out_g2_reg <= g2_reg;
            out_sat_reg <= sat_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign est_first = out_e1_reg;
    assign est_second = out_e2_reg;
    assign gain_first = out_g1_reg;
    assign gain_second = out_g2_reg;
    assign saturated = out_sat_reg;

    // A new result is only raised at the end of a program run.
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the done state");

    // The divider only runs while the sequencer waits for it.
    a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == S_DIVW))
        else $error("divider busy outside the divide wait state");

    // The step counter never runs past the end marker of the program.
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= PROG_LEN)
        else $error("step counter past program end");

    // A pending result is never overwritten before it is taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(out_e1_reg) && $stable(out_g1_reg))
        else $error("stalled result changed");

endmodule

[rtl/core/kfs_mul.sv]
// Shared fixed-point multiplier with registered product, rounding and saturation.
module kfs_mul
    import kfs_pkg::*;
#(
    parameter int FRAC_BITS = KFS_FRAC_BITS
)
(
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [Q_W-1:0] a,
    input  logic signed [Q_W-1:0] b,
    output logic signed [Q_W-1:0] res,
    output logic                  clip
);

    logic signed [2*Q_W-1:0] prod_reg;
    logic signed [2*Q_W:0]   rnd;
    logic signed [2*Q_W:0]   shf;
    logic [2*Q_W-Q_W+1:0]    hi;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    // Round half up, then floor shift and clip to the word range.
    always_comb
    begin
        rnd = {prod_reg[2*Q_W-1], prod_reg} + ((2*Q_W+1)'(1) <<< (FRAC_BITS - 1));
        shf = rnd >>> FRAC_BITS;
        hi = shf[2*Q_W:Q_W-1];
        if ((&hi) || !(|hi))
        begin
            res = shf[Q_W-1:0];
            clip = 1'b0;
        end
        else
        begin
            res = shf[2*Q_W] ? Q_MIN : Q_MAX;
            clip = 1'b1;
        end
    end

endmodule

[rtl/core/kfs_div.sv]
// Radix-2 restoring divider for the fixed-point gain quotient, one bit per cycle.
module kfs_div
    import kfs_pkg::*;
#(
    parameter int FRAC_BITS = KFS_FRAC_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [Q_W-1:0] num,
    input  logic signed [Q_W-1:0] den,
    output logic                  busy,
    output logic                  done,
    output logic signed [Q_W-1:0] q,
    output logic                  clip
);

    localparam int DVD_W = 2 * Q_W;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic             fin_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [Q_W-1:0]   rem_reg;
    logic [Q_W-1:0]   dvs_reg;
    logic             neg_reg;
    logic [Q_W-1:0]   q_reg;
    logic             clip_reg;
    logic [Q_W-1:0]   nmag;
    logic [Q_W-1:0]   dmag;
    logic [Q_W:0]     rem_t;
    logic             ge;

    assign nmag = num[Q_W-1] ? (~num + 1'b1) : num;
    assign dmag = den[Q_W-1] ? (~den + 1'b1) : den;
    assign rem_t = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge = rem_t >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (den == '0)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg <= CNT_W'(DVD_W);
                end
            end
            else if (fin_reg)
            begin
                fin_reg <= 1'b0;
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    fin_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= DVD_W'(nmag) << FRAC_BITS;
            dvs_reg <= dmag;
            rem_reg <= '0;
            neg_reg <= num[Q_W-1] ^ den[Q_W-1];
            if (den == '0)
            begin
                clip_reg <= (num != '0);
                q_reg <= (num == '0) ? '0 : (num[Q_W-1] ? Q_MIN : Q_MAX);
            end
        end
        else if (fin_reg)
        begin
            if (neg_reg)
            begin
                clip_reg <= dvd_reg > DVD_W'($unsigned(Q_MIN));
                q_reg <= (dvd_reg > DVD_W'($unsigned(Q_MIN))) ? Q_MIN
                                                               : (~dvd_reg[Q_W-1:0] + 1'b1);
            end
            else
            begin
                clip_reg <= dvd_reg > DVD_W'(Q_MAX);
                q_reg <= (dvd_reg > DVD_W'(Q_MAX)) ? Q_MAX : dvd_reg[Q_W-1:0];
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? Q_W'(rem_t - {1'b0, dvs_reg}) : rem_t[Q_W-1:0];
            dvd_reg <= {dvd_reg[DVD_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign q = q_reg;
    assign clip = clip_reg;

endmodule
